// ----- rtl/srtf_pkg.sv -----
// Shared types, widths and helpers for the SRTF schedule simulator.
package srtf_pkg;

  // Fixed field widths
  localparam int IDX_W   = 6;
  localparam int BURST_W = 8;
  localparam int ARR_W   = 8;
  localparam int TIME_W  = 14;
  localparam int MIN_W   = 9;
  localparam int TOT_W   = 20;

  // Defaults for the top-level parameters
  localparam int MAX_PROCS_DEF  = 16;
  localparam int BURST_BITS_DEF = 8;

  localparam logic [MIN_W-1:0]  MIN_NONE = '1;
  localparam logic [TIME_W-1:0] T14_MAX  = '1;
  localparam logic [TOT_W-1:0]  T20_MAX  = '1;

  // Scan token that walks the cell row once per tick
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [MIN_W-1:0] min;
    logic [IDX_W-1:0] idx;
  } tok_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [BURST_W-1:0]  wr_burst;
    logic [ARR_W-1:0]    wr_arr;
    logic                dec_en;
    logic [IDX_W-1:0]    dec_idx;
    logic                dec_done;
    logic [TIME_W:0]     finish;
    logic                copy;
    logic                shift;
  } ctl_t;

  // Result data shifted toward the head of the row
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  wait_t;
  } sh_t;

  // Clamp a 15-bit value to 14 bits
  function automatic logic [TIME_W-1:0] sat14(input logic [TIME_W:0] v);
    sat14 = v[TIME_W] ? T14_MAX : v[TIME_W-1:0];
  endfunction

endpackage

// ----- rtl/srtf_cell.sv -----
// One process slot: stores burst/arrival/remaining/wait, passes the scan token and result data.
module srtf_cell #(
  parameter int K     = 0,
  parameter int CNT_W = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  srtf_pkg::ctl_t               ctl,
  input  logic [CNT_W-1:0]             n,
  input  logic [srtf_pkg::TIME_W-1:0]  sim_time,
  input  srtf_pkg::tok_t               tok_in,
  output srtf_pkg::tok_t               tok_out,
  input  srtf_pkg::sh_t                sh_in,
  output srtf_pkg::sh_t                sh_out
);

  logic [srtf_pkg::BURST_W-1:0] burst;
  logic [srtf_pkg::ARR_W-1:0]   arr;
  logic [srtf_pkg::BURST_W-1:0] rem;
  logic [srtf_pkg::TIME_W-1:0]  wait_t;
  logic                         eligible;
  logic [srtf_pkg::TIME_W:0]    need;
  logic [srtf_pkg::TIME_W-1:0]  wait_calc;
  srtf_pkg::tok_t               tok_next;

  // Arrived, unfinished, loaded and strictly below the best so far
  assign eligible = (CNT_W'(K) < n)
                  && ({{(srtf_pkg::TIME_W-srtf_pkg::ARR_W){1'b0}}, arr} <= sim_time)
                  && (rem != '0)
                  && ({1'b0, rem} < tok_in.min);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && eligible) begin
      tok_next.found = 1'b1;
      tok_next.min   = {1'b0, rem};
      tok_next.idx   = srtf_pkg::IDX_W'(K);
    end
  end

  // Waiting time at completion: finish - burst - arrival, clamped at zero
  assign need = (srtf_pkg::TIME_W+1)'(burst) + (srtf_pkg::TIME_W+1)'(arr);
  assign wait_calc = (ctl.finish > need) ? srtf_pkg::sat14(ctl.finish - need) : '0;

  // Token stage, process state and result shift stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found <= tok_next.found;
    tok_out.min   <= tok_next.min;
    tok_out.idx   <= tok_next.idx;
    if (ctl.wr_en && ctl.wr_idx == srtf_pkg::IDX_W'(K)) begin
      burst  <= ctl.wr_burst;
      arr    <= ctl.wr_arr;
      rem    <= ctl.wr_burst;
      wait_t <= '0;
    end else if (ctl.dec_en && ctl.dec_idx == srtf_pkg::IDX_W'(K)) begin
      rem <= rem - 1'b1;
      if (ctl.dec_done) begin
        wait_t <= wait_calc;
      end
    end
    if (ctl.copy) begin
      sh_out.burst  <= burst;
      sh_out.wait_t <= wait_t;
    end else if (ctl.shift) begin
      sh_out <= sh_in;
    end
  end

endmodule

// ----- rtl/srtf_schedule_simulator.sv -----
// Top level: load sequencer, tick loop over the cell row, and result output stage.
// Usage:
//   Slave channel s_*: one beat per process, tdata = {arrival_time, burst_time},
//   tlast marks the final process and starts the schedule. Beats beyond
//   MAX_PROCS processes are dropped, a tlast on them still starts the run.
//   Master channel m_*: one beat per loaded process, in load order, with
//   process index, waiting time, turnaround time and running wait total;
//   tlast is set on the final result.
// Schedule and output flow:
//   s_tready stays high through the load phase. Each simulated tick issues a
//   scan token that passes through the row of MAX_PROCS cells, one cell per
//   cycle; the pick is applied as it returns. Once every process is complete,
//   the results are copied into the shift chain and m_tvalid rises, then one
//   result per cycle while the receiver takes them.
// Reset: rst (synchronous) empties the process set and the output register.
// Stall: results wait in the output register and the cell shift chain while
//   m_tready is low; s_tready returns high once the last result is in the
//   output register.
module srtf_schedule_simulator #(
  parameter int MAX_PROCS  = srtf_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = srtf_pkg::BURST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] burst_time, [15:8] arrival_time
  input  logic        s_tlast,   // last_process
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [5:0] process_index, [19:6] waiting_time,
                                 // [33:20] turnaround_time, [53:34] total_waiting, zero pad
  output logic        m_tlast    // last_result
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [srtf_pkg::BURST_W-1:0] BURST_MASK =
    (BURST_BITS >= srtf_pkg::BURST_W) ? '1
                                      : srtf_pkg::BURST_W'((17'd1 << BURST_BITS) - 17'd1);

  typedef enum logic [2:0] {ST_LOAD, ST_ISSUE, ST_SCAN, ST_COPY, ST_OUT} state_t;

  state_t                          state;
  logic [CNT_W-1:0]                loaded;
  logic [CNT_W-1:0]                zero_cnt;
  logic [CNT_W-1:0]                completed;
  logic [CNT_W-1:0]                out_left;
  logic [srtf_pkg::IDX_W-1:0]      out_idx;
  logic [srtf_pkg::TIME_W-1:0]     sim_time;
  logic [srtf_pkg::MIN_W-1:0]      cur_min;
  logic [srtf_pkg::IDX_W-1:0]      cur_pick;
  logic                            pick_valid;
  logic [srtf_pkg::TOT_W-1:0]      total;
  logic [srtf_pkg::IDX_W-1:0]      res_idx;
  logic [srtf_pkg::TIME_W-1:0]     res_wait;
  logic [srtf_pkg::TIME_W-1:0]     res_tat;
  logic [srtf_pkg::TOT_W-1:0]      res_total;

  srtf_pkg::ctl_t                  ctl;
  srtf_pkg::tok_t                  tok_chain [MAX_PROCS+1];
  srtf_pkg::sh_t                   sh_chain  [MAX_PROCS+1];
  srtf_pkg::tok_t                  tok_ret;

  logic                            in_beat;
  logic                            room;
  logic [srtf_pkg::BURST_W-1:0]    burst_in;
  logic                            out_load;
  logic [srtf_pkg::TOT_W:0]        total_sum;
  logic [srtf_pkg::TOT_W-1:0]      total_next;

  assign s_tready = (state == ST_LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign room     = (loaded < CNT_W'(MAX_PROCS));
  assign burst_in = s_tdata[7:0] & BURST_MASK;
  assign tok_ret  = tok_chain[MAX_PROCS];
  assign out_load = (state == ST_OUT) && (out_left != '0) && (!m_tvalid || m_tready);

  // Inject the scan token at the head of the row
  always_comb begin
    tok_chain[0].valid = (state == ST_ISSUE) && (completed != loaded);
    tok_chain[0].found = pick_valid;
    tok_chain[0].min   = cur_min;
    tok_chain[0].idx   = cur_pick;
  end

  assign sh_chain[MAX_PROCS] = '0;

  // Broadcast control to the cells
  always_comb begin
    ctl          = '0;
    ctl.wr_en    = in_beat && room;
    ctl.wr_idx   = srtf_pkg::IDX_W'(loaded);
    ctl.wr_burst = burst_in;
    ctl.wr_arr   = s_tdata[15:8];
    ctl.dec_en   = (state == ST_SCAN) && tok_ret.valid && tok_ret.found;
    ctl.dec_idx  = tok_ret.idx;
    ctl.dec_done = (tok_ret.min == srtf_pkg::MIN_W'(1));
    ctl.finish   = {1'b0, sim_time} + 1'b1;
    ctl.copy     = (state == ST_COPY);
    ctl.shift    = out_load;
  end

  // Row of process cells
  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
    srtf_cell #(.K(k), .CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .n        (loaded),
      .sim_time (sim_time),
      .tok_in   (tok_chain[k]),
      .tok_out  (tok_chain[k+1]),
      .sh_in    (sh_chain[k+1]),
      .sh_out   (sh_chain[k])
    );
  end

  // Result fields from the head of the shift chain
  assign total_sum  = {1'b0, total} + (srtf_pkg::TOT_W+1)'(sh_chain[0].wait_t);
  assign total_next = total_sum[srtf_pkg::TOT_W] ? srtf_pkg::T20_MAX
                                                 : total_sum[srtf_pkg::TOT_W-1:0];

  assign m_tdata = {2'b00, res_total, res_tat, res_wait, res_idx};

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      loaded     <= '0;
      zero_cnt   <= '0;
      completed  <= '0;
      out_left   <= '0;
      out_idx    <= '0;
      sim_time   <= '0;
      cur_min    <= srtf_pkg::MIN_NONE;
      cur_pick   <= '0;
      pick_valid <= 1'b0;
      total      <= '0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_beat) begin
            if (room) begin
              loaded <= loaded + 1'b1;
              if (burst_in == '0) begin
                zero_cnt <= zero_cnt + 1'b1;
              end
            end
            if (s_tlast) begin
              completed  <= (room && burst_in == '0) ? zero_cnt + 1'b1 : zero_cnt;
              sim_time   <= '0;
              cur_min    <= srtf_pkg::MIN_NONE;
              cur_pick   <= '0;
              pick_valid <= 1'b0;
              state      <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state <= (completed == loaded) ? ST_COPY : ST_SCAN;
        end
        ST_SCAN: begin
          // Token is back: apply one tick
          if (tok_ret.valid) begin
            if (tok_ret.found) begin
              cur_pick <= tok_ret.idx;
              if (ctl.dec_done) begin
                cur_min    <= srtf_pkg::MIN_NONE;
                pick_valid <= 1'b0;
                completed  <= completed + 1'b1;
              end else begin
                cur_min    <= tok_ret.min - 1'b1;
                pick_valid <= 1'b1;
              end
            end
            sim_time <= sim_time + 1'b1;
            state    <= ST_ISSUE;
          end
        end
        ST_COPY: begin
          out_left <= loaded;
          out_idx  <= '0;
          total    <= '0;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (out_left == CNT_W'(1));
            out_left <= out_left - 1'b1;
            out_idx  <= out_idx + 1'b1;
            total    <= total_next;
            if (out_left == CNT_W'(1)) begin
              loaded    <= '0;
              zero_cnt  <= '0;
              completed <= '0;
              state     <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_idx   <= out_idx;
      res_wait  <= sh_chain[0].wait_t;
      res_tat   <= srtf_pkg::sat14((srtf_pkg::TIME_W+1)'(sh_chain[0].burst)
                                   + (srtf_pkg::TIME_W+1)'(sh_chain[0].wait_t));
      res_total <= total_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    completed <= loaded)
    else $error("completed count exceeds loaded count");
  a_tok_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_ret.valid |-> state == ST_SCAN)
    else $error("scan token returned outside the scan phase");
  a_pick_min: assert property (@(posedge clk) disable iff (rst)
    pick_valid |-> (cur_min != srtf_pkg::MIN_NONE && cur_min != '0))
    else $error("running process has no remaining time");
  a_pick_loaded: assert property (@(posedge clk) disable iff (rst)
    (tok_ret.valid && tok_ret.found) |-> (int'(tok_ret.idx) < int'(loaded)))
    else $error("picked process outside the loaded set");
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_load) |=> out_left == $past(out_left) - 1'b1)
    else $error("result count not stepped on output load");
`endif

endmodule
